/* hdl/free_list_allocator_top_assert.svh */
// Assertion macros shared by the allocator RTL.
`ifndef FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fla_pkg.sv */
// Package with the request modes and result status codes of the allocator.
package fla_pkg;

  localparam int ADDR_W = 20;
  localparam int BYTES_W = 32;
  localparam int STATUS_W = 2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOBLK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

endpackage

/* hdl/fla_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/free_list_allocator_top.sv */
// Top level of the next-fit free-list allocator with its request sequencer.
// The block takes one request at a time and holds stall high until its result is
// registered. HEADER_BYTES must be a power of two, so a request is decoded into units
// by a shift when it is accepted. An allocation then enters the list at the rover
// in S_A_START and S_A_FIRST, visits the free-list nodes in S_A_EVAL through the
// single read port of the header RAM, and writes one more header in S_A_SPLIT when
// it splits a block; when the walk wraps, growing the arena writes a header in
// S_G_WRITE and runs a free-style walk of its own. A free reads the block header and
// then the rover, walks the list up to its place, then writes the headers of the
// freed block and its predecessor. Every request ends in S_DONE, which registers
// the result and waits while the output stalls. Throughput is set by free-list length.
module free_list_allocator_top
  import fla_pkg::*;
#(
  parameter int ARENA_UNITS = 32767,
  parameter int GROW_UNITS = 8192,
  parameter int HEADER_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                mode,
  input  logic [BYTES_W-1:0]  request_bytes,
  input  logic [ADDR_W-1:0]   block_address,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [ADDR_W-1:0]   granted_address,
  output logic [STATUS_W-1:0] status
);

  `include "free_list_allocator_top_assert.svh"

  localparam int UW = $clog2(ARENA_UNITS + 1);
  localparam int BW = UW + 1;
  localparam int DEPTH = ARENA_UNITS + 1;
  localparam int RMW = $clog2(HEADER_BYTES);
  localparam int DW = (UW + 5 > ADDR_W) ? UW + 5 : ADDR_W;
  localparam int ACAP = 4 * DEPTH + 8;
  localparam int ACW = $clog2(ACAP + 1);
  localparam int FCAP = DEPTH + 2;
  localparam int FCW = $clog2(FCAP + 1);
  localparam logic [BYTES_W:0] BYTE_LIMIT = (BYTES_W + 1)'((ARENA_UNITS - 1) * HEADER_BYTES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVDONE = 4'd2;
  localparam logic [3:0] S_A_START = 4'd3;
  localparam logic [3:0] S_A_FIRST = 4'd4;
  localparam logic [3:0] S_A_EVAL = 4'd5;
  localparam logic [3:0] S_A_SPLIT = 4'd6;
  localparam logic [3:0] S_G_WRITE = 4'd7;
  localparam logic [3:0] S_R_SIZE = 4'd8;
  localparam logic [3:0] S_R_WALK0 = 4'd9;
  localparam logic [3:0] S_R_WALK = 4'd10;
  localparam logic [3:0] S_R_Q = 4'd11;
  localparam logic [3:0] S_R_WP = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state;
  logic mode_r;
  logic [DW-1:0] dvd;
  logic [RMW-1:0] rem;
  logic ready;
  logic [UW-1:0] rover;
  logic [BW-1:0] brk;
  logic [UW-1:0] n;
  logic [UW-1:0] prev;
  logic [UW-1:0] size_prev;
  logic [UW-1:0] p;
  logic [UW-1:0] size_p;
  logic [UW-1:0] tgt;
  logic [BW-1:0] nu;
  logic [ACW-1:0] acnt;
  logic [FCW-1:0] fcnt;
  logic [UW-1:0] bp;
  logic [UW-1:0] s;
  logic [UW-1:0] q;
  logic [UW-1:0] link_b;
  logic [UW-1:0] size_b;
  logic from_grow;
  logic [ADDR_W-1:0] res_addr;
  logic [STATUS_W-1:0] res_status;
  logic res_load;

  logic we;
  logic [UW-1:0] waddr;
  logic [2*UW-1:0] wdata;
  logic [UW-1:0] raddr;
  logic [2*UW-1:0] rdata;
  logic [UW-1:0] rd_link;
  logic [UW-1:0] rd_size;

  logic [BYTES_W:0] need_bytes;
  logic [DW-1:0] unit_q;
  logic fit_ge;
  logic fit_eq;
  logic [UW-1:0] remain;
  logic [UW-1:0] cut;
  logic [BW-1:0] room;
  logic [31:0] want;
  logic [BW-1:0] nu_calc;
  logic cap_hit;
  logic found;
  logic bad_lo;
  logic bad_hi;
  logic merge_hi;
  logic merge_lo;
  logic [BW-1:0] bp_end;
  logic [BW-1:0] p_end;

  fla_ram #(
    .WIDTH(2 * UW),
    .DEPTH(DEPTH)
  ) u_hdr (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_link = rdata[2*UW-1:UW];
  assign rd_size = rdata[UW-1:0];
  assign req_stall = (state != S_IDLE);
  assign res_load = (state == S_DONE) && (!res_valid || !res_stall);

  always_comb begin
    need_bytes = {1'b0, request_bytes} + (BYTES_W + 1)'(HEADER_BYTES - 1);
    unit_q = dvd - DW'(1);
    fit_ge = (rd_size >= n);
    fit_eq = (rd_size == n);
    remain = rd_size - n;
    cut = p + remain;
    room = BW'(ARENA_UNITS + 1) - brk;
    want = (32'(n) < 32'(GROW_UNITS)) ? 32'(GROW_UNITS) : 32'(n);
    nu_calc = (want > 32'(room)) ? room : BW'(want);
    cap_hit = (acnt == ACW'(ACAP));
    found = ((bp > p) && (bp < rd_link)) || ((p >= rd_link) && ((bp > p) || (bp < rd_link)));
    bp_end = BW'(bp) + BW'(s);
    p_end = BW'(p) + BW'(size_p);
    bad_lo = (bp > p) && (p_end > BW'(bp));
    bad_hi = (q > bp) && (bp_end > BW'(q));
    merge_hi = (bp_end == BW'(q));
    merge_lo = (p_end == BW'(bp));
  end

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      S_DIVDONE: begin
        raddr = unit_q[UW-1:0];
        if (mode_r == MODE_ALLOC && !ready) begin
          we = 1'b1;
        end
      end
      S_A_START: raddr = rover;
      S_A_FIRST: raddr = rd_link;
      S_A_EVAL: begin
        raddr = rd_link;
        if (!cap_hit && fit_ge) begin
          we = 1'b1;
          if (fit_eq) begin
            waddr = prev;
            wdata = {rd_link, size_prev};
          end else begin
            waddr = p;
            wdata = {rd_link, remain};
          end
        end
      end
      S_A_SPLIT: begin
        we = 1'b1;
        waddr = tgt;
        wdata = {UW'(0), n};
      end
      S_G_WRITE: begin
        we = 1'b1;
        waddr = brk[UW-1:0];
        wdata = {UW'(0), nu[UW-1:0]};
      end
      S_R_WALK0: raddr = rover;
      S_R_WALK: raddr = rd_link;
      S_R_Q: begin
        if (!bad_lo && !bad_hi) begin
          we = 1'b1;
          waddr = bp;
          wdata = merge_hi ? {rd_link, s + rd_size} : {q, s};
        end
      end
      S_R_WP: begin
        we = 1'b1;
        waddr = p;
        wdata = merge_lo ? {link_b, size_p + size_b} : {bp, size_p};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b0;
      rover <= '0;
      brk <= BW'(1);
      res_valid <= 1'b0;
      from_grow <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            mode_r <= mode;
            if (mode == MODE_ALLOC) begin
              rem <= '0;
              if (request_bytes == '0 || {1'b0, request_bytes} > BYTE_LIMIT) begin
                res_addr <= '0;
                res_status <= ST_NOBLK;
                state <= S_DONE;
              end else begin
                dvd <= DW'(need_bytes >> RMW);
                state <= S_DIVDONE;
              end
            end else begin
              rem <= block_address[RMW-1:0];
              if (block_address == '0) begin
                res_addr <= '0;
                res_status <= ST_OK;
                state <= S_DONE;
              end else begin
                dvd <= DW'(block_address >> RMW);
                state <= S_DIVDONE;
              end
            end
          end
        end
        S_DIVDONE: begin
          from_grow <= 1'b0;
          acnt <= '0;
          res_addr <= '0;
          if (mode_r == MODE_ALLOC) begin
            n <= UW'(dvd + DW'(1));
            if (!ready) begin
              ready <= 1'b1;
              rover <= '0;
            end
            state <= S_A_START;
          end else if (rem != '0 || dvd == DW'(1) || unit_q >= DW'(brk)) begin
            res_status <= ST_REJECT;
            state <= S_DONE;
          end else begin
            bp <= unit_q[UW-1:0];
            state <= S_R_SIZE;
          end
        end
        S_A_START: state <= S_A_FIRST;
        S_A_FIRST: begin
          prev <= rover;
          size_prev <= rd_size;
          p <= rd_link;
          state <= S_A_EVAL;
        end
        S_A_EVAL: begin
          if (cap_hit) begin
            res_addr <= '0;
            res_status <= ST_NOBLK;
            state <= S_DONE;
          end else begin
            acnt <= acnt + ACW'(1);
            if (fit_ge) begin
              rover <= prev;
              if (fit_eq) begin
                res_addr <= ADDR_W'((32'(p) + 32'd1) * 32'(HEADER_BYTES));
                res_status <= ST_OK;
                state <= S_DONE;
              end else begin
                tgt <= cut;
                state <= S_A_SPLIT;
              end
            end else if (p == rover) begin
              if (brk > BW'(ARENA_UNITS)) begin
                res_addr <= '0;
                res_status <= ST_NOBLK;
                state <= S_DONE;
              end else begin
                nu <= nu_calc;
                state <= S_G_WRITE;
              end
            end else begin
              prev <= p;
              size_prev <= rd_size;
              p <= rd_link;
            end
          end
        end
        S_A_SPLIT: begin
          res_addr <= ADDR_W'((32'(tgt) + 32'd1) * 32'(HEADER_BYTES));
          res_status <= ST_OK;
          state <= S_DONE;
        end
        S_G_WRITE: begin
          bp <= brk[UW-1:0];
          s <= nu[UW-1:0];
          brk <= brk + nu;
          from_grow <= 1'b1;
          state <= S_R_WALK0;
        end
        S_R_SIZE: begin
          s <= rd_size;
          if (rd_size == '0 || (BW'(bp) + BW'(rd_size)) > brk) begin
            res_status <= ST_REJECT;
            state <= S_DONE;
          end else begin
            state <= S_R_WALK0;
          end
        end
        S_R_WALK0: begin
          p <= rover;
          fcnt <= '0;
          state <= S_R_WALK;
        end
        S_R_WALK: begin
          if (fcnt == FCW'(FCAP)) begin
            res_addr <= '0;
            res_status <= from_grow ? ST_NOBLK : ST_REJECT;
            state <= S_DONE;
          end else begin
            fcnt <= fcnt + FCW'(1);
            if (found) begin
              size_p <= rd_size;
              q <= rd_link;
              state <= S_R_Q;
            end else begin
              p <= rd_link;
            end
          end
        end
        S_R_Q: begin
          if (bad_lo || bad_hi) begin
            res_addr <= '0;
            res_status <= from_grow ? ST_NOBLK : ST_REJECT;
            state <= S_DONE;
          end else begin
            link_b <= merge_hi ? rd_link : q;
            size_b <= merge_hi ? s + rd_size : s;
            state <= S_R_WP;
          end
        end
        S_R_WP: begin
          rover <= p;
          if (from_grow) begin
            from_grow <= 1'b0;
            state <= S_A_START;
          end else begin
            res_status <= ST_OK;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_load) begin
            granted_address <= res_addr;
            status <= res_status;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FLA_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state != S_IDLE, "accepted request left the sequencer idle")
  `FLA_ASSERT_NOW(a_brk_range, 1'b1, brk >= BW'(1) && brk <= BW'(ARENA_UNITS + 1), "arena break out of range")
  `FLA_ASSERT_NOW(a_status_code, res_valid, status != 2'd3, "undefined status code on result")
  `FLA_ASSERT_NEXT(a_done_hold, state == S_DONE && res_valid && res_stall, state == S_DONE, "result dropped while output was full")

endmodule
